[rtl/core/assert_macros.svh]
// Assertion macros for the RTL core.
// Depends on nothing; the including module supplies clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/lesf_pkg.sv]
// Shared constants, types and register codes for the largest empty square finder.
// Used by every module in rtl/core.
package lesf_pkg;

	localparam int MAX_COLS = 1024;
	localparam int MAX_ROWS = 1024;

	localparam int COL_W   = $clog2(MAX_COLS);
	localparam int ROW_W   = $clog2(MAX_ROWS);
	localparam int SCORE_W = $clog2(MAX_COLS + 1);
	localparam int LEN_W   = 11;
	localparam int CHAR_W  = 8;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;

	localparam logic [LEN_W-1:0]  ROW_LENGTH_RST    = LEN_W'(1024);
	localparam logic [CHAR_W-1:0] OBSTACLE_CHAR_RST = CHAR_W'(111);
	localparam logic [LEN_W-1:0]  LEN_MAX           = LEN_W'(MAX_COLS);
	localparam logic [ROW_W-1:0]  ROW_LAST          = ROW_W'(MAX_ROWS - 1);

	typedef enum logic {
		REG_ROW_LENGTH    = 1'b0,
		REG_OBSTACLE_CHAR = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic               en;
		logic [COL_W-1:0]   wr_addr;
		logic [SCORE_W-1:0] wr_data;
		logic [COL_W-1:0]   rd_addr;
	} ls_req_t;

	typedef struct packed {
		logic [SCORE_W-1:0] size;
		logic [ROW_W-1:0]   row;
		logic [COL_W-1:0]   col;
	} best_t;

endpackage

[rtl/core/lesf_line_store.sv]
// Line store: previous-row scores, one write and one read-ahead per transaction.
// Depends on lesf_pkg.
module lesf_line_store
	import lesf_pkg::*;
(
	input  logic               clk,
	input  ls_req_t            req,
	output logic [SCORE_W-1:0] rd_data
);

	logic [SCORE_W-1:0] mem [MAX_COLS];
	logic [SCORE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.en) begin
			mem[req.wr_addr] <= req.wr_data;
			if (req.rd_addr == req.wr_addr) begin
				rd_data_q <= req.wr_data;
			end else begin
				rd_data_q <= mem[req.rd_addr];
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/core/lesf_score_unit.sv]
// Cell scoring: min-add against left, upper and diagonal scores, raster counters, best tracking.
// Depends on lesf_pkg; drives lesf_line_store through ls_req_t.
module lesf_score_unit
	import lesf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               acc,
	input  logic [CHAR_W-1:0]  cell_char,
	input  logic               last_cell,
	input  logic [LEN_W-1:0]   row_length,
	input  logic [CHAR_W-1:0]  obstacle_char,
	input  logic [SCORE_W-1:0] up,
	output ls_req_t            ls_req,
	output best_t              best_next
);

	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [SCORE_W-1:0] left_q;
	logic [SCORE_W-1:0] diag_q;
	best_t              best_q;

	logic [LEN_W-1:0]   len;
	logic [LEN_W-1:0]   col_inc;
	logic [COL_W-1:0]   col_nxt;
	logic [ROW_W-1:0]   row_nxt;
	logic [SCORE_W-1:0] min3;
	logic [SCORE_W-1:0] score;

	always_comb begin
		priority if (row_length == '0) begin
			len = LEN_W'(1);
		end else if (row_length > LEN_MAX) begin
			len = LEN_MAX;
		end else begin
			len = row_length;
		end
	end

	always_comb begin
		min3 = up;
		if (left_q < min3) begin
			min3 = left_q;
		end
		if (diag_q < min3) begin
			min3 = diag_q;
		end
	end

	always_comb begin
		priority if (cell_char == obstacle_char) begin
			score = '0;
		end else if (row_q == '0 || col_q == '0) begin
			score = SCORE_W'(1);
		end else begin
			score = min3 + SCORE_W'(1);
		end
	end

	always_comb begin
		col_inc = LEN_W'(col_q) + LEN_W'(1);
		row_nxt = row_q;
		if (col_inc >= len) begin
			col_nxt = '0;
			if (row_q < ROW_LAST) begin
				row_nxt = row_q + ROW_W'(1);
			end
		end else begin
			col_nxt = col_inc[COL_W-1:0];
		end
	end

	always_comb begin
		best_next = best_q;
		if (score > best_q.size) begin
			best_next.size = score;
			best_next.row  = row_q;
			best_next.col  = col_q;
		end
	end

	always_comb begin
		ls_req.en      = acc;
		ls_req.wr_addr = col_q;
		ls_req.wr_data = score;
		ls_req.rd_addr = last_cell ? '0 : col_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			left_q <= '0;
			diag_q <= '0;
			best_q <= '0;
		end else if (acc) begin
			if (last_cell) begin
				col_q  <= '0;
				row_q  <= '0;
				left_q <= '0;
				diag_q <= '0;
				best_q <= '0;
			end else begin
				col_q  <= col_nxt;
				row_q  <= row_nxt;
				left_q <= score;
				diag_q <= up;
				best_q <= best_next;
			end
		end
	end

endmodule

[rtl/core/largest_empty_square_finder.sv]
// Largest empty square finder: takes one map cell per cycle in row-major order and, on the
// cell marked last, returns the side and bottom-right corner of the largest obstacle-free
// square the cycle after. A new cell is taken every cycle while the result register is free
// or being drained; the rate is set by the line store, which reads the entry for the next
// cell in the same cycle that the current cell's score is written back. Depends on lesf_pkg,
// lesf_line_store, lesf_score_unit and assert_macros.svh.
`include "assert_macros.svh"

module largest_empty_square_finder
	import lesf_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,

	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready,

	input  logic                in_valid,
	output logic                in_ready,
	input  logic [CHAR_W-1:0]   cell_char,
	input  logic                last_cell,

	output logic                out_valid,
	input  logic                out_ready,
	output logic [SCORE_W-1:0]  square_size,
	output logic [ROW_W-1:0]    corner_row,
	output logic [COL_W-1:0]    corner_col
);

	logic [LEN_W-1:0]   row_length_q;
	logic [CHAR_W-1:0]  obstacle_char_q;
	reg_idx_t           reg_idx;
	logic               cfg_wr;

	logic               acc;
	ls_req_t            ls_req;
	logic [SCORE_W-1:0] up;
	best_t              best_next;
	logic               out_valid_q;
	best_t              res_q;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q    <= ROW_LENGTH_RST;
			obstacle_char_q <= OBSTACLE_CHAR_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_ROW_LENGTH:    row_length_q    <= pwdata[LEN_W-1:0];
				REG_OBSTACLE_CHAR: obstacle_char_q <= pwdata[CHAR_W-1:0];
				default:           ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ROW_LENGTH:    prdata = DATA_W'(row_length_q);
			REG_OBSTACLE_CHAR: prdata = DATA_W'(obstacle_char_q);
			default:           prdata = '0;
		endcase
	end

	assign in_ready = !out_valid_q || out_ready;
	assign acc      = in_valid && in_ready;

	lesf_line_store u_line_store (
		.clk     (clk),
		.req     (ls_req),
		.rd_data (up)
	);

	lesf_score_unit u_score_unit (
		.clk           (clk),
		.arst_n        (arst_n),
		.acc           (acc),
		.cell_char     (cell_char),
		.last_cell     (last_cell),
		.row_length    (row_length_q),
		.obstacle_char (obstacle_char_q),
		.up            (up),
		.ls_req        (ls_req),
		.best_next     (best_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc && last_cell) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && last_cell) begin
			res_q <= best_next;
		end
	end

	assign out_valid   = out_valid_q;
	assign square_size = res_q.size;
	assign corner_row  = res_q.row;
	assign corner_col  = res_q.col;

	`ASSERT_RST(a_last_gives_result, in_valid && in_ready && last_cell |=> out_valid, "last cell transaction produced no result")
	`ASSERT_RST(a_empty_corner_zero, out_valid && square_size == '0 |-> corner_row == '0 && corner_col == '0, "empty map result carries a nonzero corner")
	`ASSERT_RST(a_stall_only_when_full, !in_ready |-> out_valid && !out_ready, "input stalled with the result register free")
	`ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")

endmodule
